### sv/chi_square_bit_balance_test_macros.svh
// assertion macros for the chi-square bit-balance test
// no dependencies; included by the modules that carry assertions
`ifndef CHI_SQUARE_BIT_BALANCE_TEST_MACROS_SVH
`define CHI_SQUARE_BIT_BALANCE_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define CBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/cbb_pkg.sv
// shared types, constants and helpers of the chi-square bit-balance test
// no dependencies
package cbb_pkg;

  localparam int DEF_MAX_BLOCK_BYTES = 65536;
  localparam int DEF_MAX_BLOCKS      = 4096;

  localparam int BYTE_W = 8;
  localparam int BB_W   = 17;
  localparam int NBL_W  = 13;
  localparam int SUM_W  = 49;
  localparam int VERD_W = 2;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [BB_W-1:0]  BLOCK_BYTES_RST   = 17'd10000;
  localparam logic [NBL_W-1:0] PERIOD_BLOCKS_RST = 13'd1000;
  localparam logic [SUM_W-1:0] REJECT_LIMIT_RST  = 49'd76800000;
  localparam logic [SUM_W-1:0] WEAK_LIMIT_RST    = 49'd80000;

  typedef enum logic [1:0] {
    REG_BLOCK_BYTES   = 2'd0,
    REG_PERIOD_BLOCKS = 2'd1,
    REG_REJECT_LIMIT  = 2'd2,
    REG_WEAK_LIMIT    = 2'd3
  } cbb_reg_t;

  typedef enum logic [VERD_W-1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_REJECT = 2'd1,
    VERDICT_WEAK   = 2'd2
  } cbb_verdict_t;

  // per-stage control: vld marks a block end, last marks a verdict period end
  typedef struct packed {
    logic vld;
    logic last;
  } cbb_ctl_t;

  function automatic logic [3:0] popcount8(input logic [BYTE_W-1:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

endpackage

### sv/cbb_regs.sv
// apb-style configuration registers of the chi-square bit-balance test
// depends on cbb_pkg
module cbb_regs
  import cbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output logic [BB_W-1:0]    block_bytes,
  output logic [NBL_W-1:0]   period_blocks,
  output logic [SUM_W-1:0]   reject_limit,
  output logic [SUM_W-1:0]   weak_limit
);

  logic [BB_W-1:0]  block_bytes_r;
  logic [NBL_W-1:0] period_blocks_r;
  logic [SUM_W-1:0] reject_limit_r;
  logic [SUM_W-1:0] weak_limit_r;
  cbb_reg_t         sel;
  logic             wr;

  assign sel    = cbb_reg_t'(paddr[ADDR_W-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r   <= BLOCK_BYTES_RST;
      period_blocks_r <= PERIOD_BLOCKS_RST;
      reject_limit_r  <= REJECT_LIMIT_RST;
      weak_limit_r    <= WEAK_LIMIT_RST;
    end else if (wr) begin
      unique case (sel)
        REG_BLOCK_BYTES:   block_bytes_r   <= pwdata[BB_W-1:0];
        REG_PERIOD_BLOCKS: period_blocks_r <= pwdata[NBL_W-1:0];
        REG_REJECT_LIMIT:  reject_limit_r  <= pwdata[SUM_W-1:0];
        REG_WEAK_LIMIT:    weak_limit_r    <= pwdata[SUM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_BLOCK_BYTES:   prdata = DATA_W'(block_bytes_r);
      REG_PERIOD_BLOCKS: prdata = DATA_W'(period_blocks_r);
      REG_REJECT_LIMIT:  prdata = DATA_W'(reject_limit_r);
      REG_WEAK_LIMIT:    prdata = DATA_W'(weak_limit_r);
    endcase
  end

  assign block_bytes   = block_bytes_r;
  assign period_blocks = period_blocks_r;
  assign reject_limit  = reject_limit_r;
  assign weak_limit    = weak_limit_r;

endmodule

### sv/cbb_count.sv
// input register, ones counting and block/period sequencing
// depends on cbb_pkg and the assertion macro header
`include "chi_square_bit_balance_test_macros.svh"
module cbb_count
  import cbb_pkg::*;
#(
  parameter int  MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  parameter int  MAX_BLOCKS      = DEF_MAX_BLOCKS,
  localparam int OC_W            = $clog2(8 * MAX_BLOCK_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_sample_byte,
  input  logic [BB_W-1:0]   block_bytes,
  input  logic [NBL_W-1:0]  period_blocks,
  output cbb_ctl_t          s1_ctl,
  output logic [OC_W-1:0]   s1_ones,
  output logic [OC_W-1:0]   s1_exp
);

  localparam int NB_W = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int BI_W = $clog2(MAX_BLOCK_BYTES);
  localparam int NK_W = $clog2(MAX_BLOCKS + 1);
  localparam int BK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CB_W = (NB_W > BB_W) ? NB_W : BB_W;
  localparam int CK_W = (NK_W > NBL_W) ? NK_W : NBL_W;

  logic              s0_vld_r;
  logic [BYTE_W-1:0] s0_byte_r;
  logic [BI_W-1:0]   byte_index_r, byte_index_nxt;
  logic [BK_W-1:0]   block_index_r, block_index_nxt;
  logic [OC_W-1:0]   ones_count_r, ones_count_nxt;
  logic [NB_W-1:0]   nbytes;
  logic [NK_W-1:0]   nblocks;
  logic [OC_W-1:0]   ones_sum;
  logic              blk_end;
  logic              per_end;
  cbb_ctl_t          s1_ctl_r;
  logic [OC_W-1:0]   s1_ones_r;
  logic [OC_W-1:0]   s1_exp_r;

  // zero counts as one, oversize saturates
  always_comb begin
    if (block_bytes == '0) begin
      nbytes = NB_W'(1);
    end else if (CB_W'(block_bytes) > CB_W'(MAX_BLOCK_BYTES)) begin
      nbytes = NB_W'(MAX_BLOCK_BYTES);
    end else begin
      nbytes = NB_W'(block_bytes);
    end
    if (period_blocks == '0) begin
      nblocks = NK_W'(1);
    end else if (CK_W'(period_blocks) > CK_W'(MAX_BLOCKS)) begin
      nblocks = NK_W'(MAX_BLOCKS);
    end else begin
      nblocks = NK_W'(period_blocks);
    end
  end

  always_comb begin
    ones_sum = ones_count_r + OC_W'(popcount8(s0_byte_r));
    // a shrunk size ends the block at once
    blk_end  = !((NB_W'(byte_index_r) + NB_W'(1)) < nbytes);
    per_end  = blk_end && !((NK_W'(block_index_r) + NK_W'(1)) < nblocks);
    byte_index_nxt  = blk_end ? '0 : byte_index_r + BI_W'(1);
    block_index_nxt = per_end ? '0 : (blk_end ? block_index_r + BK_W'(1) : block_index_r);
    ones_count_nxt  = blk_end ? '0 : ones_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r      <= 1'b0;
      s1_ctl_r      <= '0;
      byte_index_r  <= '0;
      block_index_r <= '0;
      ones_count_r  <= '0;
    end else if (adv) begin
      s0_vld_r      <= in_valid;
      s1_ctl_r.vld  <= s0_vld_r && blk_end;
      s1_ctl_r.last <= s0_vld_r && per_end;
      if (s0_vld_r) begin
        byte_index_r  <= byte_index_nxt;
        block_index_r <= block_index_nxt;
        ones_count_r  <= ones_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_byte_r <= in_sample_byte;
      s1_ones_r <= ones_sum;
      s1_exp_r  <= OC_W'(nbytes) << 2;
    end
  end

  assign s1_ctl  = s1_ctl_r;
  assign s1_ones = s1_ones_r;
  assign s1_exp  = s1_exp_r;

  `CBB_ASSERT_NEXT(a_ones_clear, clk, rst_n, adv && s0_vld_r && blk_end,
                   ones_count_r == '0, "ones count not cleared after block end")
  `CBB_ASSERT_NOW(a_last_in_block, clk, rst_n, s1_ctl_r.last, s1_ctl_r.vld,
                  "period end without block end")

endmodule

### sv/cbb_square.sv
// deviation and squaring stages
// depends on cbb_pkg
module cbb_square
  import cbb_pkg::*;
#(
  parameter int  MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  localparam int OC_W            = $clog2(8 * MAX_BLOCK_BYTES + 1),
  localparam int SQ_W            = 2 * OC_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  cbb_ctl_t        s1_ctl,
  input  logic [OC_W-1:0] s1_ones,
  input  logic [OC_W-1:0] s1_exp,
  output cbb_ctl_t        s3_ctl,
  output logic [SQ_W-1:0] s3_sq
);

  cbb_ctl_t        s2_ctl_r;
  cbb_ctl_t        s3_ctl_r;
  logic [OC_W-1:0] dev;
  logic [OC_W-1:0] s2_d_r;
  logic [SQ_W-1:0] sq_prod;
  logic [SQ_W-1:0] s3_sq_r;

  assign dev     = (s1_ones >= s1_exp) ? s1_ones - s1_exp : s1_exp - s1_ones;
  assign sq_prod = s2_d_r * s2_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= s1_ctl;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_d_r  <= dev;
      s3_sq_r <= sq_prod;
    end
  end

  assign s3_ctl = s3_ctl_r;
  assign s3_sq  = s3_sq_r;

endmodule

### sv/cbb_accum.sv
// saturating square sum, verdict and output register
// depends on cbb_pkg and the assertion macro header
`include "chi_square_bit_balance_test_macros.svh"
module cbb_accum
  import cbb_pkg::*;
#(
  parameter int  MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  localparam int SQ_W            = 2 * $clog2(8 * MAX_BLOCK_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cbb_ctl_t          s3_ctl,
  input  logic [SQ_W-1:0]   s3_sq,
  input  logic [SUM_W-1:0]  reject_limit,
  input  logic [SUM_W-1:0]  weak_limit,
  input  logic              out_ready,
  output logic              adv,
  output logic              out_valid,
  output logic [VERD_W-1:0] out_verdict,
  output logic [SUM_W-1:0]  out_deviation_square_sum
);

  logic [SUM_W-1:0] square_sum_r;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic             s4_res_vld_r;
  logic [SUM_W-1:0] s4_sum_r;
  cbb_verdict_t     verdict;
  logic             out_valid_r;
  cbb_verdict_t     out_verdict_r;
  logic [SUM_W-1:0] out_sum_r;

  // carry out of the sum means saturation
  assign sum_wide = {1'b0, square_sum_r} + (SUM_W + 1)'(s3_sq);
  assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  // hold only when a finished result meets a full output register
  assign adv = !(s4_res_vld_r && out_valid_r && !out_ready);

  always_comb begin
    priority if (s4_sum_r > reject_limit) begin
      verdict = VERDICT_REJECT;
    end else if (s4_sum_r < weak_limit) begin
      verdict = VERDICT_WEAK;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_sum_r <= '0;
      s4_res_vld_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (adv) begin
        s4_res_vld_r <= s3_ctl.vld && s3_ctl.last;
        if (s3_ctl.vld) begin
          square_sum_r <= s3_ctl.last ? '0 : sum_sat;
        end
      end
      if (adv && s4_res_vld_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_ctl.vld) begin
      s4_sum_r <= sum_sat;
    end
    if (adv && s4_res_vld_r) begin
      out_verdict_r <= verdict;
      out_sum_r     <= s4_sum_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_verdict              = out_verdict_r;
  assign out_deviation_square_sum = out_sum_r;

  `CBB_ASSERT_NEXT(a_sum_clear, clk, rst_n, adv && s3_ctl.vld && s3_ctl.last, square_sum_r == '0, "square sum not cleared after verdict period")
  `CBB_ASSERT_NEXT(a_res_held, clk, rst_n, s4_res_vld_r && !adv, s4_res_vld_r && $stable(s4_sum_r), "pending result lost while held")

endmodule

### sv/chi_square_bit_balance_test.sv
// top level of the chi-square bit-balance health test
// depends on cbb_pkg, cbb_regs, cbb_count, cbb_square, cbb_accum
//
//  channel  handshake           payload                                   dir
//  -------  ------------------  ----------------------------------------  ---
//  in       in_valid/in_ready   in_sample_byte[7:0]                        in
//  out      out_valid/out_ready out_verdict[1:0], out_deviation_square_sum out
//  config   psel/penable/pready paddr[4:0], pwdata/prdata[63:0] (8*index)  in
//
// one byte accepted per cycle unless the pipeline is held; the pipeline is
// input register, counting, deviation, square, accumulate, output register,
// and a verdict period's result passes through each of these in that order
// synchronous active-low reset clears counters, square sum and valid flags;
// configuration registers reset to block size 10000, 1000 blocks, limits
// 76800000 and 80000
// the whole pipeline holds only when a finished result meets an output word
// that is not yet taken; otherwise input flows while a result waits
module chi_square_bit_balance_test
  import cbb_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_sample_byte,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VERD_W-1:0] out_verdict,
  output logic [SUM_W-1:0]  out_deviation_square_sum,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // ones count is wide enough for eight ones per byte of the largest block
  localparam int OC_W = $clog2(8 * MAX_BLOCK_BYTES + 1);
  localparam int SQ_W = 2 * OC_W;

  logic [BB_W-1:0]  block_bytes;
  logic [NBL_W-1:0] period_blocks;
  logic [SUM_W-1:0] reject_limit;
  logic [SUM_W-1:0] weak_limit;
  logic             adv;
  cbb_ctl_t         s1_ctl;
  logic [OC_W-1:0]  s1_ones;
  logic [OC_W-1:0]  s1_exp;
  cbb_ctl_t         s3_ctl;
  logic [SQ_W-1:0]  s3_sq;

  // input is taken whenever the pipeline moves
  assign in_ready = adv;

  cbb_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .block_bytes   (block_bytes),
    .period_blocks (period_blocks),
    .reject_limit  (reject_limit),
    .weak_limit    (weak_limit)
  );

  // byte counting and block/period boundaries
  cbb_count #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
    .MAX_BLOCKS      (MAX_BLOCKS)
  ) u_count (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_valid),
    .in_sample_byte (in_sample_byte),
    .block_bytes    (block_bytes),
    .period_blocks  (period_blocks),
    .s1_ctl         (s1_ctl),
    .s1_ones        (s1_ones),
    .s1_exp         (s1_exp)
  );

  // |ones - 4 * bytes| then its square, one register each
  cbb_square #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_square (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .s1_ctl  (s1_ctl),
    .s1_ones (s1_ones),
    .s1_exp  (s1_exp),
    .s3_ctl  (s3_ctl),
    .s3_sq   (s3_sq)
  );

  // saturating sum, verdict against pre-scaled limits, output register
  cbb_accum #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_accum (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .s3_ctl                   (s3_ctl),
    .s3_sq                    (s3_sq),
    .reject_limit             (reject_limit),
    .weak_limit               (weak_limit),
    .out_ready                (out_ready),
    .adv                      (adv),
    .out_valid                (out_valid),
    .out_verdict              (out_verdict),
    .out_deviation_square_sum (out_deviation_square_sum)
  );

endmodule
